FILE: hdl/cle_pkg.sv
// package: types, constants and codes for the console line editor
package cle_pkg;
	localparam int LINE_CHARS = 64;
	localparam int HIST_N = 5;
	localparam int LW = $clog2(LINE_CHARS);
	localparam int HW = $clog2(HIST_N);
	localparam int HDW = $clog2(HIST_N + 1);
	localparam int HTW = $clog2(HIST_N * LINE_CHARS);
	localparam int QDEPTH = 4;
	localparam int QW = $clog2(QDEPTH);

	localparam logic [7:0] CH_ESC = 8'h1B;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_LBR = 8'h5B;
	localparam logic [7:0] CH_O = 8'h4F;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_B = 8'h42;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	localparam logic [1:0] K_TX = 2'd0;
	localparam logic [1:0] K_ERASE = 2'd1;
	localparam logic [1:0] K_LINE = 2'd2;
	localparam logic [1:0] K_NONE = 2'd3;

	typedef struct packed {
		logic action;
		logic [7:0] rx_byte;
		logic [6:0] max_len;
	} in_item_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic [5:0] erase_count;
		logic [5:0] line_length;
		logic last;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_PRINT, OP_ERASE, OP_ENTER, OP_UP, OP_DOWN, OP_CONSUME, OP_ESC
	} op_t;

	typedef struct packed {
		op_t op;
		logic [7:0] ch;
		logic [6:0] max_len;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DISPATCH, ST_ENTER, ST_CMP, ST_COPY, ST_RECALL, ST_RTEXT,
		ST_CONSUME, ST_CTEXT
	} state_t;
endpackage

FILE: hdl/cle_front.sv
// front end: byte classification, escape tracking and command queue
module cle_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input cle_pkg::in_item_t in_item,
	output logic cmd_valid,
	output cle_pkg::cmd_t cmd,
	input logic cmd_take
);
	import cle_pkg::*;

	logic [1:0] esc_q;
	logic line_rdy_q;
	cmd_t q_mem [QDEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0] cnt_q;
	logic keep;
	cmd_t c;
	logic acc;
	logic [7:0] b;

	assign full = (cnt_q == (QW+1)'(QDEPTH));
	assign acc = push && !full;
	assign b = in_item.rx_byte;

	always_comb begin
		keep = 1'b0;
		c.op = OP_PRINT;
		c.ch = b;
		c.max_len = in_item.max_len;
		if (in_item.action) begin
			keep = 1'b1;
			c.op = OP_CONSUME;
		end else if (esc_q == 2'd0) begin
			if (b == CH_ESC) begin
				keep = 1'b0;
			end else if (b == CH_CR || b == CH_LF) begin
				keep = 1'b1;
				c.op = OP_ENTER;
			end else if (b == CH_BS || b == CH_DEL) begin
				keep = 1'b1;
				c.op = OP_ERASE;
			end else if (b >= CH_SP && b <= CH_TILDE) begin
				keep = 1'b1;
			end
		end else if (esc_q == 2'd2) begin
			if (b == CH_A) begin
				keep = 1'b1;
				c.op = OP_UP;
			end else if (b == CH_B) begin
				keep = 1'b1;
				c.op = OP_DOWN;
			end
		end
	end

	// a line is ready from enter until the next consume transfer; bytes in between are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 2'd0;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
			line_rdy_q <= 1'b0;
		end else begin
			if (acc && !in_item.action && !line_rdy_q) begin
				if (esc_q == 2'd1)
					esc_q <= (b == CH_LBR || b == CH_O) ? 2'd2 : 2'd0;
				else if (esc_q == 2'd2)
					esc_q <= 2'd0;
				else if (b == CH_ESC)
					esc_q <= 2'd1;
			end
			if (acc && keep && (in_item.action || !line_rdy_q)) begin
				q_mem[wr_q] <= c;
				wr_q <= wr_q + 1'b1;
			end
			if (acc && in_item.action)
				line_rdy_q <= 1'b0;
			else if (acc && keep && !line_rdy_q && c.op == OP_ENTER)
				line_rdy_q <= 1'b1;
			if (cmd_take)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q
				+ ((acc && keep && (in_item.action || !line_rdy_q))
					? (QW+1)'(1) : (QW+1)'(0))
				- (cmd_take ? (QW+1)'(1) : (QW+1)'(0));
		end
	end

	assign cmd_valid = (cnt_q != '0);
	assign cmd = q_mem[rd_q];

`ifndef SYNTHESIS
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cnt_q != '0) else $error("queue underflow");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		full |=> cnt_q != '0) else $error("queue count lost");
	a_esc_range: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != 2'd3) else $error("escape phase corrupt");
`endif
endmodule

FILE: hdl/cle_back.sv
// back end: line store, history ring and result sequencing
module cle_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cle_pkg::cmd_t cmd,
	output logic cmd_take,
	output logic res_valid,
	output cle_pkg::out_item_t res,
	input logic res_take
);
	import cle_pkg::*;

	logic [7:0] line_mem [LINE_CHARS];
	logic [7:0] hist_mem [HIST_N*LINE_CHARS];
	logic [LW-1:0] hlen_q [HIST_N];

	state_t st_q, st_d;
	cmd_t cmd_q;
	logic [LW-1:0] cnt_q;
	logic rdy_q;
	logic [HDW-1:0] used_q, depth_q;
	logic [HW-1:0] wslot_q, slot_q;
	logic [LW:0] i_q;
	logic [LW-1:0] len_q;
	logic same_q;
	logic [7:0] line_rd, hist_rd;
	logic phase_q;
	out_item_t ob_q;
	logic ob_v_q;

	assign res_valid = ob_v_q;
	assign res = ob_q;

	logic can_emit;
	assign can_emit = !ob_v_q || res_take;

	function automatic logic [HW-1:0] slot_back(input logic [HW-1:0] w,
		input logic [HDW-1:0] d);
		logic [HW+HDW:0] t;
		begin
			t = (HW+HDW+1)'(w) + (HW+HDW+1)'(HIST_N) - (HW+HDW+1)'(d);
			if (t >= (HW+HDW+1)'(HIST_N))
				t = t - (HW+HDW+1)'(HIST_N);
			slot_back = t[HW-1:0];
		end
	endfunction

	function automatic logic [HTW-1:0] haddr(input logic [HW-1:0] s,
		input logic [LW-1:0] k);
		haddr = HTW'(s) * HTW'(LINE_CHARS) + HTW'(k);
	endfunction

	// memory reads: registered, the address is presented ahead of the data
	logic [LW-1:0] lra;
	logic [HTW-1:0] hra;
	always_comb begin
		lra = i_q[LW-1:0];
		hra = haddr(slot_q, i_q[LW-1:0]);
	end
	always_ff @(posedge clk) begin
		line_rd <= line_mem[lra];
		hist_rd <= hist_mem[hra];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (cmd_valid) st_d = ST_DISPATCH;
			default: st_d = st_q;
		endcase
	end

	assign cmd_take = (st_q == ST_IDLE) && cmd_valid;

	logic [LW:0] clen;
	always_comb begin
		clen = (cmd_q.max_len == 7'd0) ? '0 : (LW+1)'(cmd_q.max_len - 7'd1);
		if (clen > (LW+1)'(cnt_q))
			clen = (LW+1)'(cnt_q);
	end

	// a new result enters the output register this cycle
	logic ob_set;
	always_comb begin
		ob_set = 1'b0;
		unique case (st_q)
			ST_DISPATCH: if (can_emit) begin
				unique case (cmd_q.op)
					OP_PRINT: ob_set = !rdy_q && cnt_q < LW'(LINE_CHARS - 1);
					OP_ERASE: ob_set = !rdy_q && cnt_q != '0;
					OP_ENTER: ob_set = !rdy_q;
					OP_CONSUME: ob_set = !rdy_q || clen == '0;
					default: ob_set = 1'b0;
				endcase
			end
			ST_ENTER, ST_RECALL: ob_set = can_emit;
			ST_RTEXT, ST_CTEXT: ob_set = phase_q && can_emit;
			default: ob_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ob_v_q <= 1'b0;
		else if (ob_set)
			ob_v_q <= 1'b1;
		else if (res_take)
			ob_v_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			rdy_q <= 1'b0;
			used_q <= '0;
			depth_q <= '0;
			wslot_q <= '0;
			slot_q <= '0;
			i_q <= '0;
			len_q <= '0;
			same_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: if (cmd_valid) begin
					cmd_q <= cmd;
					st_q <= st_d;
				end
				ST_DISPATCH: if (can_emit) begin
					i_q <= '0;
					phase_q <= 1'b0;
					unique case (cmd_q.op)
						OP_PRINT: begin
							if (!rdy_q && cnt_q < LW'(LINE_CHARS - 1)) begin
								line_mem[cnt_q] <= cmd_q.ch;
								cnt_q <= cnt_q + 1'b1;
								ob_q <= '{K_TX, cmd_q.ch, 6'd0, 6'd0, 1'b1};
							end
							st_q <= ST_IDLE;
						end
						OP_ERASE: begin
							if (!rdy_q && cnt_q != '0) begin
								cnt_q <= cnt_q - 1'b1;
								ob_q <= '{K_ERASE, 8'd0, 6'd1, 6'd0, 1'b1};
							end
							st_q <= ST_IDLE;
						end
						OP_ENTER: begin
							if (rdy_q) st_q <= ST_IDLE;
							else begin
								ob_q <= '{K_TX, CH_CR, 6'd0, 6'd0, 1'b0};
								st_q <= ST_ENTER;
							end
						end
						OP_UP: begin
							if (!rdy_q && used_q != '0 && depth_q < used_q) begin
								depth_q <= depth_q + 1'b1;
								slot_q <= slot_back(wslot_q, depth_q + 1'b1);
								st_q <= ST_RECALL;
							end else st_q <= ST_IDLE;
						end
						OP_DOWN: begin
							if (!rdy_q && depth_q != '0) begin
								depth_q <= depth_q - 1'b1;
								slot_q <= slot_back(wslot_q, depth_q - 1'b1);
								st_q <= ST_RECALL;
							end else st_q <= ST_IDLE;
						end
						OP_CONSUME: begin
							if (!rdy_q) begin
								ob_q <= '{K_NONE, 8'd0, 6'd0, 6'd0, 1'b1};
								st_q <= ST_IDLE;
							end else if (clen == '0) begin
								ob_q <= '{K_LINE, 8'd0, 6'd0, 6'd0, 1'b1};
								cnt_q <= '0;
								rdy_q <= 1'b0;
								st_q <= ST_IDLE;
							end else begin
								len_q <= clen[LW-1:0];
								st_q <= ST_CTEXT;
							end
						end
						default: st_q <= ST_IDLE;
					endcase
				end
				ST_ENTER: if (can_emit) begin
					ob_q <= '{K_TX, phase_q ? CH_LF : CH_CR, 6'd0, 6'd0, phase_q};
					if (phase_q) begin
						rdy_q <= 1'b1;
						depth_q <= '0;
						slot_q <= slot_back(wslot_q, HDW'(1));
						same_q <= (used_q != '0)
							&& (hlen_q[slot_back(wslot_q, HDW'(1))] == cnt_q);
						i_q <= '0;
						phase_q <= 1'b0;
						st_q <= (cnt_q == '0) ? ST_IDLE : ST_CMP;
					end else phase_q <= 1'b1;
				end
				ST_CMP: begin
					// compare newest history entry with the line, one char at a time: a read phase, then a compare phase
					if (!phase_q) phase_q <= 1'b1;
					else begin
						if (line_rd != hist_rd) same_q <= 1'b0;
						if (i_q + 1'b1 == (LW+1)'(cnt_q)) begin
							i_q <= '0;
							phase_q <= 1'b0;
							slot_q <= wslot_q;
							st_q <= ST_COPY;
						end else begin
							i_q <= i_q + 1'b1;
							phase_q <= 1'b0;
						end
					end
				end
				ST_COPY: begin
					if (same_q && line_rd == hist_rd && !phase_q) begin
						st_q <= ST_IDLE;
					end else if (same_q) begin
						st_q <= ST_IDLE;
					end else if (!phase_q) phase_q <= 1'b1;
					else begin
						hist_mem[haddr(wslot_q, i_q[LW-1:0])] <= line_rd;
						phase_q <= 1'b0;
						if (i_q + 1'b1 == (LW+1)'(cnt_q)) begin
							hlen_q[wslot_q] <= cnt_q;
							wslot_q <= (wslot_q == HW'(HIST_N - 1)) ? '0 : wslot_q + 1'b1;
							if (used_q < HDW'(HIST_N)) used_q <= used_q + 1'b1;
							st_q <= ST_IDLE;
						end else i_q <= i_q + 1'b1;
					end
				end
				ST_RECALL: if (can_emit) begin
					ob_q <= '{K_ERASE, 8'd0, 6'(cnt_q), 6'd0,
						depth_q == '0 || hlen_q[slot_q] == '0};
					cnt_q <= '0;
					len_q <= (depth_q == '0) ? '0 : hlen_q[slot_q];
					i_q <= '0;
					phase_q <= 1'b0;
					st_q <= (depth_q == '0 || hlen_q[slot_q] == '0) ? ST_IDLE : ST_RTEXT;
				end
				ST_RTEXT: begin
					if (!phase_q) phase_q <= 1'b1;
					else if (can_emit) begin
						line_mem[i_q[LW-1:0]] <= hist_rd;
						ob_q <= '{K_TX, hist_rd, 6'd0, 6'd0,
							i_q + 1'b1 == (LW+1)'(len_q)};
						phase_q <= 1'b0;
						if (i_q + 1'b1 == (LW+1)'(len_q)) begin
							cnt_q <= len_q;
							st_q <= ST_IDLE;
						end else i_q <= i_q + 1'b1;
					end
				end
				ST_CTEXT: begin
					if (!phase_q) phase_q <= 1'b1;
					else if (can_emit) begin
						ob_q <= '{K_LINE, line_rd, 6'd0, 6'(len_q),
							i_q + 1'b1 == (LW+1)'(len_q)};
						phase_q <= 1'b0;
						if (i_q + 1'b1 == (LW+1)'(len_q)) begin
							cnt_q <= '0;
							rdy_q <= 1'b0;
							st_q <= ST_IDLE;
						end else i_q <= i_q + 1'b1;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= used_q) else $error("recall depth beyond history");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= HDW'(HIST_N)) else $error("history count overflow");
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < LW'(LINE_CHARS - 1) || cnt_q == LW'(LINE_CHARS - 1))
		else $error("line overflow");
`endif
endmodule

FILE: hdl/console_line_editor_with_history.sv
// top level: console line editor with command history
// One transfer in gives zero to 64 result transfers. Bytes that are dropped or
// only move the escape state never reach the back end. An enter runs a history
// compare of the line with the newest entry and then a copy of the line into the
// history, skipping the copy when the line repeats the newest entry; a recall and
// a consume step through the characters one at a time, each paced by the
// registered read of the line and history memories in the back-end sequencer.
// A four-entry command queue lets bytes arrive while the back end is busy.
module console_line_editor_with_history (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input cle_pkg::in_item_t in_item,
	output logic empty,
	input logic pop,
	output cle_pkg::out_item_t out_item
);
	import cle_pkg::*;

	logic cmd_valid, cmd_take, res_valid;
	cmd_t cmd;

	cle_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.cmd_valid, .cmd, .cmd_take
	);

	cle_back u_back (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take,
		.res_valid, .res(out_item), .res_take(pop && res_valid)
	);

	assign empty = !res_valid;
endmodule

FILE: tb/sv/tb_console_line_editor_with_history.sv
// testbench for the console line editor: directed and random byte streams checked against a predictor
module tb_console_line_editor_with_history;
	import cle_pkg::*;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	in_item_t in_item;
	logic empty;
	logic pop;
	out_item_t out_item;

	console_line_editor_with_history i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_item(in_item),
		.empty(empty),
		.pop(pop),
		.out_item(out_item)
	);

	// editor model state
	logic [7:0] ed_line [LINE_CHARS];
	int ed_count;
	bit ed_ready;
	int ed_esc;
	logic [7:0] ed_hist [HIST_N][LINE_CHARS];
	int ed_hist_len [HIST_N];
	int ed_hist_used;
	int ed_hist_slot;
	int ed_depth;

	out_item_t echo_q[$];
	out_item_t step_res[$];
	int errors;
	int n_items;
	int n_results;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_cycles;
	longint cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("timeout at %0t", $time);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic out_item_t mk(logic [1:0] k, logic [7:0] v, int e, int l);
		out_item_t r;
		r.kind = k;
		r.value = v;
		r.erase_count = e[5:0];
		r.line_length = l[5:0];
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void emit(out_item_t r);
		if (step_res.size() < 64)
			step_res.push_back(r);
	endfunction

	function automatic void hist_store();
		int newest;
		bit same;
		if (ed_count == 0)
			return;
		newest = (ed_hist_slot + HIST_N - 1) % HIST_N;
		same = ed_hist_used > 0 && ed_hist_len[newest] == ed_count;
		for (int i = 0; i < ed_count && same; i++)
			if (ed_hist[newest][i] != ed_line[i])
				same = 0;
		if (same)
			return;
		for (int i = 0; i < ed_count; i++)
			ed_hist[ed_hist_slot][i] = ed_line[i];
		ed_hist_len[ed_hist_slot] = ed_count;
		ed_hist_slot = (ed_hist_slot + 1) % HIST_N;
		if (ed_hist_used < HIST_N)
			ed_hist_used++;
	endfunction

	function automatic void recall_line();
		int idx;
		int len;
		emit(mk(K_ERASE, 8'h00, ed_count, 0));
		ed_count = 0;
		if (ed_depth == 0)
			return;
		idx = (ed_hist_slot + HIST_N - ed_depth) % HIST_N;
		len = ed_hist_len[idx];
		if (len > LINE_CHARS - 1)
			len = LINE_CHARS - 1;
		for (int i = 0; i < len; i++) begin
			ed_line[i] = ed_hist[idx][i];
			emit(mk(K_TX, ed_line[i], 0, 0));
		end
		ed_count = len;
	endfunction

	function automatic void predict_edit(in_item_t it);
		int len;
		logic [7:0] c;
		step_res.delete();
		c = it.rx_byte;
		if (it.action) begin
			if (!ed_ready) begin
				emit(mk(K_NONE, 8'h00, 0, 0));
			end else begin
				len = it.max_len > 0 ? int'(it.max_len) - 1 : 0;
				if (len > ed_count)
					len = ed_count;
				if (len == 0)
					emit(mk(K_LINE, 8'h00, 0, 0));
				for (int i = 0; i < len; i++)
					emit(mk(K_LINE, ed_line[i], 0, len));
				ed_count = 0;
				ed_ready = 0;
			end
		end else if (ed_ready) begin
		end else if (ed_esc == 1) begin
			ed_esc = (c == CH_LBR || c == CH_O) ? 2 : 0;
		end else if (ed_esc != 0) begin
			ed_esc = 0;
			if (c == CH_A) begin
				if (ed_hist_used > 0 && ed_depth < ed_hist_used) begin
					ed_depth++;
					recall_line();
				end
			end else if (c == CH_B) begin
				if (ed_depth > 0) begin
					ed_depth--;
					recall_line();
				end
			end
		end else if (c == CH_ESC) begin
			ed_esc = 1;
		end else if (c == CH_CR || c == CH_LF) begin
			emit(mk(K_TX, CH_CR, 0, 0));
			emit(mk(K_TX, CH_CR, 0, 0));
			emit(mk(K_TX, CH_LF, 0, 0));
			hist_store();
			ed_ready = 1;
			ed_depth = 0;
		end else if (c == CH_BS || c == CH_DEL) begin
			if (ed_count > 0) begin
				ed_count--;
				emit(mk(K_ERASE, 8'h00, 1, 0));
			end
		end else if (c >= CH_SP && c <= CH_TILDE) begin
			if (ed_count < LINE_CHARS - 1) begin
				ed_line[ed_count] = c;
				ed_count++;
				emit(mk(K_TX, c, 0, 0));
			end
		end
		if (step_res.size() > 0)
			step_res[step_res.size() - 1].last = 1'b1;
		foreach (step_res[i])
			echo_q.push_back(step_res[i]);
	endfunction

	// result side: random stall, long hold-off on request
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= recv_stall_pct);
		end
		if (arst_n && pop && !empty) begin
			n_results <= n_results + 1;
			if (echo_q.size() == 0) begin
				$display("%0t unexpected result %p", $time, out_item);
				errors <= errors + 1;
			end else begin
				if (out_item !== echo_q[0]) begin
					$display("%0t mismatch: expected %p actual %p", $time, echo_q[0], out_item);
					errors <= errors + 1;
				end
				void'(echo_q.pop_front());
			end
		end
	end

	task automatic send_item(logic act, logic [7:0] b, logic [6:0] ml);
		in_item_t it;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		it.action = act;
		it.rx_byte = b;
		it.max_len = ml;
		push <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_edit(it);
		n_items++;
	endtask

	task automatic send_byte(logic [7:0] b);
		send_item(1'b0, b, 7'($urandom_range(127)));
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (echo_q.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(1'b1, 8'hFF, 7'd64);
		send_byte(CH_BS);
		send_text("ab");
		send_byte(8'h09);
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(CH_DEL);
		send_byte(8'h7E);
		send_byte(CH_CR);
		send_byte(8'h41);
		send_item(1'b1, 8'h00, 7'd1);
		send_text("xy");
		send_byte(CH_LF);
		send_item(1'b1, 8'h00, 7'd127);
		send_byte(CH_CR);
		send_item(1'b1, 8'h00, 7'd0);
		send_byte(CH_ESC);
		send_byte(CH_O);
		send_byte(CH_A);
		send_byte(CH_ESC);
		send_byte(CH_LBR);
		send_byte(CH_B);
		send_byte(CH_ESC);
		send_byte(8'h5A);
		send_byte(CH_ESC);
	endtask

	task automatic test_long_line();
		send_byte(CH_LBR);
		send_byte(CH_CR);
		send_item(1'b1, 8'h00, 7'd64);
		for (int i = 0; i < 66; i++)
			send_byte(8'($urandom_range(32, 126)));
		send_byte(CH_CR);
		send_item(1'b1, 8'h00, 7'd3);
		send_byte(CH_ESC);
		send_text("[A");
		send_byte(CH_CR);
		send_item(1'b1, 8'h00, 7'd127);
	endtask

	task automatic random_byte();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			send_byte(8'($urandom_range(32, 126)));
		else if (r < 55)
			send_byte($urandom_range(1) ? CH_BS : CH_DEL);
		else if (r < 75) begin
			send_byte(CH_ESC);
			send_byte($urandom_range(3) != 0 ? ($urandom_range(1) ? CH_LBR : CH_O) :
				8'($urandom_range(255)));
			send_byte($urandom_range(4) != 0 ? ($urandom_range(1) ? CH_A : CH_B) :
				8'($urandom_range(255)));
		end else if (r < 85) begin
			send_byte($urandom_range(1) ? CH_CR : CH_LF);
			send_item(1'b1, 8'($urandom_range(255)), 7'($urandom_range(127)));
		end else if (r < 92)
			send_item(1'b1, 8'($urandom_range(255)), 7'($urandom_range(127)));
		else
			send_byte(8'($urandom_range(255)));
	endtask

	task automatic test_random(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) random_byte();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 400;
		repeat (20) send_byte(8'($urandom_range(32, 126)));
		send_byte(CH_ESC);
		send_text("[A");
		send_byte(CH_ESC);
		send_text("[B");
		wait_drained();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		in_item = '0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_cycles = 0;
		cycles = 0;
		ed_count = 0;
		ed_ready = 0;
		ed_esc = 0;
		ed_hist_used = 0;
		ed_hist_slot = 0;
		ed_depth = 0;
		foreach (ed_hist_len[i])
			ed_hist_len[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_line();
		wait_drained();
		test_random(12, 0, 0);
		test_random(12, 53, 0);
		test_random(12, 0, 53);
		test_random(12, 30, 30);
		test_backpressure();
		test_random(12, 30, 30);
		wait_drained();
		$display("sent %0d items and checked %0d results: editing, escapes, recall,",
			n_items, n_results);
		$display("history wrap, consume lengths, stalls and a full input queue");
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
